@@ hdl/twcd_pkg.sv @@
// Package for the textured wall column drawer: word types, command codes,
// fixed-point constants and the controller/datapath interface structs.
// No dependencies.
package twcd_pkg;

	// Screen and texture geometry.
	localparam int SCREEN_ROWS = 480;
	localparam int HALF_ROWS   = SCREEN_ROWS / 2;
	localparam int TEX_SIZE    = 64;
	localparam int TEX_BITS    = $clog2(TEX_SIZE);

	// Field widths of the words.
	localparam int CMD_W     = 2;
	localparam int TEX_SEL_W = 3;
	localparam int ADDR_W    = 2 * TEX_BITS;
	localparam int COLOR_W   = 32;
	localparam int ROW_W     = 9;
	localparam int COL_W     = 10;
	localparam int DIST_W    = 16;

	// Texture store geometry.
	localparam int STORE_AW    = TEX_SEL_W + ADDR_W;
	localparam int STORE_DEPTH = 1 << STORE_AW;

	// Arithmetic widths: line height, half height, Q6.16 step and Q16.16 position.
	localparam int HEIGHT_W = DIST_W + 1;
	localparam int HALF_W   = HEIGHT_W - 1;
	localparam int STEP_W   = TEX_BITS + 16;
	localparam int POS_W    = 32;

	// Shared divider widths.
	localparam int DIVN_W = STEP_W + 1;
	localparam int DIVD_W = HEIGHT_W;

	// Dividends: rows in Q8.8 scale for the height, texture size in Q16.16.
	localparam logic [DIVN_W-1:0] HEIGHT_NUM = DIVN_W'(SCREEN_ROWS * 256);
	localparam logic [DIVN_W-1:0] STEP_NUM   = DIVN_W'(TEX_SIZE * 65536);

	// Color darkening mask for the shaded side.
	localparam logic [COLOR_W-1:0] SHADE_MASK = 32'h007F7F7F;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COLUMN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ROW    = 2'd2;

	// Request word.
	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [TEX_SEL_W-1:0] tex_select;
		logic [ADDR_W-1:0]    texel_addr;
		logic [COLOR_W-1:0]   texel_value;
		logic [COL_W-1:0]     screen_column;
		logic [DIST_W-1:0]    wall_distance;
		logic [TEX_BITS-1:0]  tex_column;
		logic                 shaded_side;
	} req_word_t;

	// Pixel word.
	typedef struct packed {
		logic [ROW_W-1:0]   pix_row;
		logic [COL_W-1:0]   pix_column;
		logic [COLOR_W-1:0] pix_color;
		logic               last_in_column;
	} pix_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_texel;
		logic row_fire;
		logic col_start;
		logic div_start;
		logic div_step;
		logic ld_height;
		logic ld_span;
		logic ld_step;
		logic ld_pos;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic span_active;
		logic pipe_free;
		logic div_done;
		logic span_nonempty;
	} dp_status_t;

endpackage

@@ hdl/textured_wall_column_drawer.sv @@
// Top level of the textured wall column drawer: joins controller and datapath.
// Depends on twcd_pkg, twcd_ctrl, twcd_dpath.
//
// Usage: request words arrive on req_valid/req_ready/req_word, pixel words
// leave on pix_valid/pix_ready/pix_word.
// A texel-write word loads one texel into the 32768-entry texture store. A
// column word holds req_ready low through its setup: the line height and
// the texture step each come from a 23-step restoring divider whose result is
// loaded on its done pulse, followed by one multiply for the starting texture
// position. When the span comes out empty the second division is skipped and
// req_ready returns once the span is loaded. A row word on a live span issues
// a store read, and its pixel word passes through the read stage and the
// output register; row words stream at one per cycle while the receiver keeps
// taking pixels. Row words with no live span and unused command codes are
// taken and dropped.
// When the receiver stalls, one pixel waits in the output register and one
// more in the read stage; after that req_ready drops until a pixel is taken.
// Reset clears the controller, the span and the pixel stages; the texture
// store is not cleared and must be written before it is read.
module textured_wall_column_drawer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  twcd_pkg::req_word_t req_word,
	output logic                pix_valid,
	input  logic                pix_ready,
	output twcd_pkg::pix_word_t pix_word
);

	twcd_pkg::ctrl_cmd_t  cmd;
	twcd_pkg::dp_status_t status;

	twcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req_word.cmd),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	twcd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.cmd       (cmd),
		.status    (status),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_word  (pix_word)
	);

endmodule

@@ hdl/twcd_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on twcd_pkg for its widths.
module twcd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [twcd_pkg::DIVN_W-1:0]  dividend,
	input  logic [twcd_pkg::DIVD_W-1:0]  divisor,
	output logic                         done,
	output logic [twcd_pkg::DIVN_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(twcd_pkg::DIVN_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [twcd_pkg::DIVN_W-1:0] num_q;
	logic [twcd_pkg::DIVD_W-1:0] rem_q;
	logic [twcd_pkg::DIVD_W-1:0] den_q;
	logic [twcd_pkg::DIVD_W:0]   trial;
	logic [twcd_pkg::DIVD_W:0]   diff;
	logic                        fits;

	// Shift the next dividend bit into the remainder and try the subtraction.
	assign trial = {rem_q, num_q[twcd_pkg::DIVN_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Sequencing: busy for one cycle per quotient bit, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(twcd_pkg::DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers; the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[twcd_pkg::DIVN_W-2:0], fits};
			rem_q <= fits ? diff[twcd_pkg::DIVD_W-1:0] : trial[twcd_pkg::DIVD_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

@@ hdl/twcd_ctrl.sv @@
// Controller state machine of the wall column drawer: takes request words and
// sequences the column setup. Depends on twcd_pkg.
module twcd_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic [twcd_pkg::CMD_W-1:0]     req_cmd,
	output logic                           req_ready,
	input  twcd_pkg::dp_status_t           status,
	output twcd_pkg::ctrl_cmd_t            cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIVH = 5'b00010,
		ST_SPAN = 5'b00100,
		ST_DIVS = 5'b01000,
		ST_MUL  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   req_fire;

	assign req_ready = (state_q == ST_IDLE) && status.pipe_free;
	assign req_fire  = req_valid && req_ready;

	// Next state and datapath commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req_cmd)
						twcd_pkg::CMD_WRITE: begin
							cmd.wr_texel = 1'b1;
						end
						twcd_pkg::CMD_COLUMN: begin
							cmd.col_start = 1'b1;
							cmd.div_start = 1'b1;
							state_next    = ST_DIVH;
						end
						twcd_pkg::CMD_ROW: begin
							cmd.row_fire = status.span_active;
						end
						default: begin
						end
					endcase
				end
			end
			ST_DIVH: begin
				if (status.div_done) begin
					cmd.ld_height = 1'b1;
					state_next    = ST_SPAN;
				end
			end
			ST_SPAN: begin
				cmd.ld_span = 1'b1;
				if (status.span_nonempty) begin
					cmd.div_start = 1'b1;
					cmd.div_step  = 1'b1;
					state_next    = ST_DIVS;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_DIVS: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					cmd.ld_step = 1'b1;
					state_next  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.ld_pos = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

@@ hdl/twcd_dpath.sv @@
// Datapath of the wall column drawer: span registers, shared divider, offset
// multiplier, texture store and the pixel output stages. Depends on twcd_pkg, twcd_div.
module twcd_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  twcd_pkg::req_word_t   req_word,
	input  twcd_pkg::ctrl_cmd_t   cmd,
	output twcd_pkg::dp_status_t  status,
	output logic                  pix_valid,
	input  logic                  pix_ready,
	output twcd_pkg::pix_word_t   pix_word
);

	localparam int ROW_W    = twcd_pkg::ROW_W;
	localparam int HALF_W   = twcd_pkg::HALF_W;
	localparam int STEP_W   = twcd_pkg::STEP_W;
	localparam int POS_W    = twcd_pkg::POS_W;
	localparam int TEX_BITS = twcd_pkg::TEX_BITS;

	// Column state.
	logic [twcd_pkg::COL_W-1:0]     column_q;
	logic [twcd_pkg::TEX_SEL_W-1:0] texture_q;
	logic [TEX_BITS-1:0]            texcol_q;
	logic                           shade_q;
	logic [ROW_W-1:0]               row_now_q;
	logic [ROW_W-1:0]               span_end_q;
	logic [POS_W-1:0]               tex_pos_q;
	logic [STEP_W-1:0]              tex_step_q;
	logic                           span_active_q;
	logic [twcd_pkg::HEIGHT_W-1:0]  height_q;
	logic [HALF_W-1:0]              offset_q;

	// Divider hookup.
	logic [twcd_pkg::DIVN_W-1:0]    div_num;
	logic [twcd_pkg::DIVD_W-1:0]    div_den;
	logic [twcd_pkg::DIVN_W-1:0]    div_quot;
	logic                           div_done;
	logic [twcd_pkg::DIST_W-1:0]    dist_adj;

	// Span geometry.
	logic [HALF_W-1:0]              half;
	logic                           half_big;
	logic [ROW_W-1:0]               first_row;
	logic [ROW_W-1:0]               stop_row;
	logic [HALF_W-1:0]              offset;
	logic [HALF_W+STEP_W-1:0]       product;
	logic                           row_last;

	// Texture store and pixel stages.
	logic [twcd_pkg::COLOR_W-1:0]   store_mem [twcd_pkg::STORE_DEPTH];
	logic [twcd_pkg::STORE_AW-1:0]  wr_addr;
	logic [twcd_pkg::STORE_AW-1:0]  rd_addr;
	logic [twcd_pkg::COLOR_W-1:0]   rdata_s1;
	logic [ROW_W-1:0]               row_s1;
	logic [twcd_pkg::COL_W-1:0]     col_s1;
	logic                           last_s1;
	logic                           shade_s1;
	logic                           valid_s1;
	logic [twcd_pkg::COLOR_W-1:0]   color_s1;
	logic                           pix_valid_q;
	twcd_pkg::pix_word_t            pix_q;
	logic                           out_take;

	// A zero distance is treated as the smallest step, 1/256.
	assign dist_adj = (req_word.wall_distance == '0) ? twcd_pkg::DIST_W'(1)
	                                                 : req_word.wall_distance;
	assign div_num  = cmd.div_step ? twcd_pkg::STEP_NUM : twcd_pkg::HEIGHT_NUM;
	assign div_den  = cmd.div_step ? height_q : {1'b0, dist_adj};

	twcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Clamp the span to the screen; the offset is how far the top is cut off.
	assign half      = height_q[twcd_pkg::HEIGHT_W-1:1];
	assign half_big  = half >= HALF_W'(twcd_pkg::HALF_ROWS);
	assign first_row = half_big ? '0 : ROW_W'(HALF_W'(twcd_pkg::HALF_ROWS) - half);
	assign stop_row  = half_big ? ROW_W'(twcd_pkg::SCREEN_ROWS)
	                            : ROW_W'(HALF_W'(twcd_pkg::HALF_ROWS) + half);
	assign offset    = half_big ? (half - HALF_W'(twcd_pkg::HALF_ROWS)) : '0;

	// Starting texture position, truncated to Q16.16.
	assign product = {{STEP_W{1'b0}}, offset_q} * {{HALF_W{1'b0}}, tex_step_q};

	assign row_last = ({1'b0, row_now_q} + (ROW_W + 1)'(1)) >= {1'b0, span_end_q};

	// Column and span registers.
	always_ff @(posedge clk) begin
		if (cmd.col_start) begin
			column_q  <= req_word.screen_column;
			texture_q <= req_word.tex_select;
			texcol_q  <= req_word.tex_column;
			shade_q   <= req_word.shaded_side;
		end
		if (cmd.ld_height) begin
			height_q <= div_quot[twcd_pkg::HEIGHT_W-1:0];
		end
		if (cmd.ld_span) begin
			row_now_q  <= first_row;
			span_end_q <= stop_row;
			offset_q   <= offset;
			tex_step_q <= '0;
			tex_pos_q  <= '0;
		end else if (cmd.ld_step) begin
			tex_step_q <= div_quot[STEP_W-1:0];
		end else if (cmd.ld_pos) begin
			tex_pos_q <= product[POS_W-1:0];
		end else if (cmd.row_fire) begin
			tex_pos_q <= tex_pos_q + {{(POS_W - STEP_W){1'b0}}, tex_step_q};
			row_now_q <= row_now_q + 1'b1;
		end
	end

	// The span goes live once its start position is known and ends on its last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_active_q <= 1'b0;
		end else if (cmd.col_start) begin
			span_active_q <= 1'b0;
		end else if (cmd.ld_pos) begin
			span_active_q <= 1'b1;
		end else if (cmd.row_fire && row_last) begin
			span_active_q <= 1'b0;
		end
	end

	// Texture store: one write port for texel words, one registered read per row.
	assign wr_addr = {req_word.tex_select, req_word.texel_addr};
	assign rd_addr = {texture_q, tex_pos_q[16 +: TEX_BITS], texcol_q};

	always_ff @(posedge clk) begin
		if (cmd.wr_texel) begin
			store_mem[wr_addr] <= req_word.texel_value;
		end
		if (cmd.row_fire) begin
			rdata_s1 <= store_mem[rd_addr];
		end
	end

	// Pixel fields travel beside the store read.
	always_ff @(posedge clk) begin
		if (cmd.row_fire) begin
			row_s1   <= row_now_q;
			col_s1   <= column_q;
			last_s1  <= row_last;
			shade_s1 <= shade_q;
		end
	end

	assign out_take = !pix_valid_q || pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (cmd.row_fire) begin
				valid_s1 <= 1'b1;
			end else if (out_take) begin
				valid_s1 <= 1'b0;
			end
			if (out_take) begin
				pix_valid_q <= valid_s1;
			end
		end
	end

	// Shaded faces get half brightness with the alpha byte cleared.
	assign color_s1 = shade_s1 ? ((rdata_s1 >> 1) & twcd_pkg::SHADE_MASK) : rdata_s1;

	// Output register holds the pixel word until the receiver takes it.
	always_ff @(posedge clk) begin
		if (valid_s1 && out_take) begin
			pix_q.pix_row        <= row_s1;
			pix_q.pix_column     <= col_s1;
			pix_q.pix_color      <= color_s1;
			pix_q.last_in_column <= last_s1;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix_word  = pix_q;

	// Status back to the controller.
	assign status.span_active   = span_active_q;
	assign status.pipe_free     = !valid_s1 || out_take;
	assign status.div_done      = div_done;
	assign status.span_nonempty = half != '0;

endmodule

@@ hdl/twcd_checker.sv @@
// Port-level checks of the wall column drawer, bound to its top level.
// Depends on twcd_pkg and textured_wall_column_drawer.
module twcd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input twcd_pkg::req_word_t req_word,
	input logic                pix_valid,
	input logic                pix_ready,
	input twcd_pkg::pix_word_t pix_word
);

	// A stalled pixel word stays put.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_word))
		else $error("pixel word changed while stalled");

	// Column setup blocks new words on the following cycle.
	a_column_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_word.cmd == twcd_pkg::CMD_COLUMN |=> !req_ready)
		else $error("word accepted during column setup");

	// Every pixel row lies on the screen.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pix_word.pix_row < twcd_pkg::ROW_W'(twcd_pkg::SCREEN_ROWS))
		else $error("pixel row off screen");

endmodule

bind textured_wall_column_drawer twcd_checker u_checker (.*);
